// ===== sv/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsfd_pkg;

	// Parse phase, one-hot
	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXT16   = 6'b000100,
		PH_EXT64   = 6'b001000,
		PH_MASK    = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	// Result event codes
	localparam logic [2:0] EV_DATA       = 3'd0;
	localparam logic [2:0] EV_EMPTY_MSG  = 3'd1;
	localparam logic [2:0] EV_PING       = 3'd2;
	localparam logic [2:0] EV_EMPTY_PING = 3'd3;
	localparam logic [2:0] EV_CLOSE      = 3'd4;
	localparam logic [2:0] EV_FAIL       = 3'd5;

	// Opcodes
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// Close codes
	localparam logic [15:0] CODE_NORMAL   = 16'd1000;
	localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
	localparam logic [15:0] CODE_TOO_BIG  = 16'd1009;

	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;
	localparam logic [6:0] CTRL_MAX   = 7'd125;
	localparam logic [31:0] MAX_MSG_RESET = 32'd1048576;

	// Verdict of the header checks plus updated fragmentation state
	typedef struct packed {
		logic        fail;
		logic [15:0] code;
		logic        frag;
		logic        frag_bin;
		logic [31:0] total;
	} hdr_chk_t;

endpackage
`default_nettype wire

// ===== sv/websocket_frame_deframer.sv =====
// Top level: byte-serial WebSocket client frame parser and unmasker.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------
//  in       | in_valid / in_ready         | rx_byte
//  out      | out_valid / out_ready       | event_res byte_value is_binary last
//           |                             | close_code send_close
//  cfg      | cfg_we (no wait)            | cfg_wdata -> max_message_size
//
// One byte per clock unless the output register stalls. A request is parsed in
// the input register; its result (if any) lands in the output register.
// The output register stalls the parser; the input register keeps taking a byte
// in any cycle the parser drains it. Reset clears all parse state and sets the
// size limit to 1048576. After close or failure every byte is taken and dropped.
`default_nettype none
module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_res,
	output logic [7:0]       byte_value,
	output logic             is_binary,
	output logic             last,
	output logic [15:0]      close_code,
	output logic             send_close,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	import wsfd_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic        valid_s2;
	logic [2:0]  ev_s2;
	logic [7:0]  val_s2;
	logic        bin_s2;
	logic        last_s2;
	logic [15:0] code_s2;
	logic        send_s2;

	// parse state
	logic [31:0] max_size_q;
	phase_t      phase_q,   n_phase;
	logic        final_q,   n_final;
	logic [3:0]  op_q,      n_op;
	logic [63:0] len_q,     n_len;   // extended length, then bytes left
	logic [2:0]  cnt_q,     n_cnt;
	logic [31:0] key_q,     n_key;
	logic [1:0]  kidx_q,    n_kidx;
	logic        first_q,   n_first;
	logic        frag_q,    n_frag;
	logic        fbin_q,    n_fbin;
	logic [31:0] total_q,   n_total;
	logic        csent_q,   n_csent;
	logic [7:0]  cch_q,     n_cch;
	logic        closed_q,  n_closed;

	logic        proc;
	logic        has_res;
	logic [2:0]  r_ev;
	logic [7:0]  r_val;
	logic        r_bin;
	logic        r_last;
	logic [15:0] r_code;
	logic        r_send;

	logic [63:0] shifted;
	logic [63:0] hc_len;
	logic [2:0]  cnt_inc;
	logic [7:0]  key_byte;
	logic [7:0]  unmasked;
	logic        lastb;
	logic        cur_bin;
	logic [15:0] peer_code;
	hdr_chk_t    chk;

	assign proc     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || proc;

	assign shifted = {len_q[55:0], byte_s1};
	assign hc_len  = (phase_q == PH_HDR1) ? {57'd0, byte_s1[6:0]} : shifted;
	assign cnt_inc = cnt_q + 3'd1;
	assign lastb   = (len_q == 64'd1);
	assign cur_bin = (op_q == OP_CONT) ? fbin_q : (op_q == OP_BIN);
	assign unmasked  = byte_s1 ^ key_byte;
	assign peer_code = {cch_q, unmasked};

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	wsfd_hdr_check u_hdr_check (
		.opcode    (op_q),
		.final_bit (final_q),
		.len       (hc_len),
		.limit     (max_size_q),
		.frag      (frag_q),
		.frag_bin  (fbin_q),
		.total     (total_q),
		.chk       (chk)
	);

	always_comb begin
		logic hdr_done;
		logic do_fin;
		logic [2:0] fin_ev;
		logic [15:0] fin_code;

		hdr_done = 1'b0;
		do_fin   = 1'b0;
		fin_ev   = EV_FAIL;
		fin_code = CODE_PROTOCOL;

		n_phase  = phase_q;
		n_final  = final_q;
		n_op     = op_q;
		n_len    = len_q;
		n_cnt    = cnt_q;
		n_key    = key_q;
		n_kidx   = kidx_q;
		n_first  = first_q;
		n_frag   = frag_q;
		n_fbin   = fbin_q;
		n_total  = total_q;
		n_csent  = csent_q;
		n_cch    = cch_q;
		n_closed = closed_q;

		has_res = 1'b0;
		r_ev    = EV_DATA;
		r_val   = 8'd0;
		r_bin   = 1'b0;
		r_last  = 1'b0;
		r_code  = 16'd0;
		r_send  = 1'b0;

		if (!closed_q) begin
			case (phase_q)
				PH_HDR0: begin
					n_final = byte_s1[7];
					n_op    = byte_s1[3:0];
					if (byte_s1[6:4] != 3'd0) begin
						do_fin = 1'b1;
					end else begin
						n_phase = PH_HDR1;
					end
				end
				PH_HDR1: begin
					if (!byte_s1[7]) begin
						do_fin = 1'b1;
					end else if (byte_s1[6:0] == LEN_EXT16 ||
						     byte_s1[6:0] == LEN_EXT64) begin
						n_phase = (byte_s1[6:0] == LEN_EXT16) ? PH_EXT16 : PH_EXT64;
						n_len   = 64'd0;
						n_cnt   = 3'd0;
					end else begin
						hdr_done = 1'b1;
					end
				end
				PH_EXT16: begin
					n_len = shifted;
					n_cnt = cnt_inc;
					if (cnt_inc >= 3'd2) begin
						if (shifted < 64'd126) do_fin = 1'b1;
						else hdr_done = 1'b1;
					end
				end
				PH_EXT64: begin
					n_len = shifted;
					n_cnt = cnt_inc;
					if (cnt_inc == 3'd0) begin
						// shortest encoding and clear top bit
						if (shifted[63:16] == 48'd0 || shifted[63]) do_fin = 1'b1;
						else hdr_done = 1'b1;
					end
				end
				PH_MASK: begin
					n_key = {key_q[23:0], byte_s1};
					n_cnt = cnt_inc;
					if (cnt_inc >= 3'd4) begin
						n_cnt = 3'd0;
						if (len_q != 64'd0) begin
							n_phase = PH_PAYLOAD;
						end else begin
							n_phase = PH_HDR0;
							if (op_q <= OP_BIN) begin
								if (final_q) begin
									has_res = 1'b1;
									r_ev    = EV_EMPTY_MSG;
									r_bin   = cur_bin;
									r_last  = 1'b1;
								end
							end else if (op_q == OP_PING) begin
								has_res = 1'b1;
								r_ev    = EV_EMPTY_PING;
								r_last  = 1'b1;
							end else if (op_q == OP_CLOSE) begin
								do_fin   = 1'b1;
								fin_ev   = EV_CLOSE;
								fin_code = CODE_NORMAL;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					if (lastb) begin
						n_phase = PH_HDR0;
					end else begin
						n_len   = len_q - 64'd1;
						n_kidx  = kidx_q + 2'd1;
						n_first = 1'b0;
					end
					if (op_q == OP_CLOSE) begin
						if (first_q) begin
							if (lastb) do_fin = 1'b1;
							else n_cch = unmasked;
						end else if (peer_code inside {[16'd3000:16'd4999],
							[16'd1000:16'd1003], [16'd1007:16'd1011]}) begin
							do_fin   = 1'b1;
							fin_ev   = EV_CLOSE;
							fin_code = peer_code;
						end else begin
							do_fin = 1'b1;
						end
					end else if (op_q == OP_PING) begin
						has_res = 1'b1;
						r_ev    = EV_PING;
						r_val   = unmasked;
						r_last  = lastb;
					end else if (op_q != OP_PONG) begin
						has_res = 1'b1;
						r_ev    = EV_DATA;
						r_val   = unmasked;
						r_bin   = cur_bin;
						r_last  = final_q && lastb;
					end
				end
				default: begin
					n_phase = PH_HDR0;
				end
			endcase

			if (hdr_done) begin
				if (chk.fail) begin
					do_fin   = 1'b1;
					fin_code = chk.code;
				end else begin
					n_frag  = chk.frag;
					n_fbin  = chk.frag_bin;
					n_total = chk.total;
					n_len   = hc_len;
					n_kidx  = 2'd0;
					n_first = 1'b1;
					n_cnt   = 3'd0;
					n_phase = PH_MASK;
				end
			end

			if (do_fin) begin
				has_res  = 1'b1;
				r_ev     = fin_ev;
				r_val    = 8'd0;
				r_bin    = 1'b0;
				r_last   = 1'b0;
				r_code   = fin_code;
				r_send   = !csent_q;
				n_csent  = 1'b1;
				n_closed = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			max_size_q <= MAX_MSG_RESET;
			phase_q    <= PH_HDR0;
			final_q    <= 1'b0;
			op_q       <= 4'd0;
			len_q      <= 64'd0;
			cnt_q      <= 3'd0;
			key_q      <= 32'd0;
			kidx_q     <= 2'd0;
			first_q    <= 1'b0;
			frag_q     <= 1'b0;
			fbin_q     <= 1'b0;
			total_q    <= 32'd0;
			csent_q    <= 1'b0;
			cch_q      <= 8'd0;
			closed_q   <= 1'b0;
		end else begin
			if (cfg_we) max_size_q <= cfg_wdata;

			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (proc) valid_s1 <= 1'b0;

			if (proc && has_res) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;

			if (proc) begin
				phase_q  <= n_phase;
				final_q  <= n_final;
				op_q     <= n_op;
				len_q    <= n_len;
				cnt_q    <= n_cnt;
				key_q    <= n_key;
				kidx_q   <= n_kidx;
				first_q  <= n_first;
				frag_q   <= n_frag;
				fbin_q   <= n_fbin;
				total_q  <= n_total;
				csent_q  <= n_csent;
				cch_q    <= n_cch;
				closed_q <= n_closed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
		if (proc && has_res) begin
			ev_s2   <= r_ev;
			val_s2  <= r_val;
			bin_s2  <= r_bin;
			last_s2 <= r_last;
			code_s2 <= r_code;
			send_s2 <= r_send;
		end
	end

	assign out_valid  = valid_s2;
	assign event_res  = ev_s2;
	assign byte_value = val_s2;
	assign is_binary  = bin_s2;
	assign last       = last_s2;
	assign close_code = code_s2;
	assign send_close = send_s2;

	// once closed, a drained result is never followed by another
	a_closed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(closed_q && valid_s2 && out_ready) |=> !valid_s2)
		else $error("result after connection closed");

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (len_q != 64'd0))
		else $error("payload phase with no bytes left");

	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ev_s2 == EV_FAIL) |->
		(code_s2 == CODE_PROTOCOL || code_s2 == CODE_TOO_BIG))
		else $error("bad failure close code");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (ev_s2 == EV_FAIL || ev_s2 == EV_CLOSE)) |-> (closed_q && csent_q))
		else $error("close or failure without closed state");

endmodule
`default_nettype wire

// ===== sv/wsfd_hdr_check.sv =====
// Frame header checks once the payload length is known.
`default_nettype none
module wsfd_hdr_check (
	input  wire logic [3:0]       opcode,
	input  wire logic             final_bit,
	input  wire logic [63:0]      len,
	input  wire logic [31:0]      limit,
	input  wire logic             frag,
	input  wire logic             frag_bin,
	input  wire logic [31:0]      total,
	output wsfd_pkg::hdr_chk_t    chk
);
	import wsfd_pkg::*;

	logic        proto_bad;
	logic        len_over;
	logic        sum_over;
	logic        ctrl_long;
	logic [32:0] sum;

	assign sum       = {1'b0, total} + {1'b0, len[31:0]};
	assign len_over  = (len[63:32] != 32'd0) || (len[31:0] > limit);
	// both operands are 32 bits wide, so the 33-bit sum does not wrap
	assign sum_over  = frag && (sum > {1'b0, limit});
	assign ctrl_long = (len[63:7] != 57'd0) || (len[6:0] > CTRL_MAX);

	always_comb begin
		proto_bad = 1'b0;
		if (opcode[3]) begin
			proto_bad = !final_bit || ctrl_long || (opcode > OP_PONG);
		end else begin
			proto_bad = opcode > OP_BIN;
		end

		chk.fail     = 1'b0;
		chk.code     = CODE_PROTOCOL;
		chk.frag     = frag;
		chk.frag_bin = frag_bin;
		chk.total    = total;

		if (proto_bad) begin
			chk.fail = 1'b1;
		end else if (len_over || sum_over) begin
			chk.fail = 1'b1;
			chk.code = CODE_TOO_BIG;
		end else if (opcode == OP_CONT) begin
			if (!frag) begin
				chk.fail = 1'b1;
			end else if (final_bit) begin
				chk.frag  = 1'b0;
				chk.total = 32'd0;
			end else begin
				chk.total = sum[31:0];
			end
		end else if (!opcode[3]) begin
			// text or binary
			if (frag) begin
				chk.fail = 1'b1;
			end else if (!final_bit) begin
				chk.frag     = 1'b1;
				chk.frag_bin = (opcode == OP_BIN);
				chk.total    = len[31:0];
			end
		end
	end

endmodule
`default_nettype wire
